// ===== rtl/encoder_detent_quantizer_assert.svh =====
// assertion macros for the encoder detent quantizer
`ifndef ENCODER_DETENT_QUANTIZER_ASSERT_SVH
`define ENCODER_DETENT_QUANTIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on i_clk, idle in reset
`define EDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, idle in reset
`define EDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EDQ_ASSERT_NOW(label, ante, cons, msg)
`define EDQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/edq_pkg.sv =====
// shared types, codes and constants of the encoder detent quantizer
package edq_pkg;

    // command codes
    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    // configuration register indexes
    localparam logic CFG_CPD   = 1'b0;
    localparam logic CFG_GUARD = 1'b1;

    // reset values of the configuration registers
    localparam logic [14:0] CPD_RESET   = 15'd4;
    localparam logic [31:0] GUARD_RESET = 32'd0;

    // saturation limits of the pending delta
    localparam logic signed [7:0] PEND_MAX = 8'sd127;
    localparam logic signed [7:0] PEND_MIN = -8'sd128;

    // largest step count applied in one feed
    localparam logic [7:0] STEP_CLAMP = 8'd255;

    // divider geometry: 17-bit magnitude by 15-bit detent size
    localparam int DIVIDEND_W = 17;
    localparam int DIVISOR_W  = 15;
    localparam int CNT_W      = 5;
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIVIDEND_W);

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_STEP,
        S_OUT
    } t_state;

    // divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

endpackage

// ===== rtl/edq_div.sv =====
// restoring divider, one quotient bit per cycle
module edq_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  edq_pkg::t_div_req  i_req,
    output edq_pkg::t_div_rsp  o_rsp
);

    logic                             r_busy;
    logic [edq_pkg::CNT_W-1:0]        r_cnt;
    logic [edq_pkg::DIVISOR_W-1:0]    r_rem;
    logic [edq_pkg::DIVIDEND_W-1:0]   r_quo;
    logic [edq_pkg::DIVISOR_W-1:0]    r_divisor;
    logic                             r_done;

    logic [edq_pkg::DIVISOR_W:0]      w_rem_sh;
    logic [edq_pkg::DIVISOR_W+1:0]    w_trial;
    logic                             w_fit;
    logic [edq_pkg::DIVISOR_W-1:0]    n_rem;
    logic [edq_pkg::DIVIDEND_W-1:0]   n_quo;

    // shift in the next dividend bit and try the subtraction
    always_comb begin
        w_rem_sh = {r_rem, r_quo[edq_pkg::DIVIDEND_W-1]};
        w_trial  = {1'b0, w_rem_sh} - {2'b00, r_divisor};
        w_fit    = !w_trial[edq_pkg::DIVISOR_W+1];
        n_rem    = w_fit ? w_trial[edq_pkg::DIVISOR_W-1:0]
                         : w_rem_sh[edq_pkg::DIVISOR_W-1:0];
        n_quo    = {r_quo[edq_pkg::DIVIDEND_W-2:0], w_fit};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= edq_pkg::DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== rtl/encoder_detent_quantizer.sv =====
// Encoder detent quantizer: one item at a time. A feed that moves the count
// passes from transfer to result through the restoring divider that splits
// the summed count into whole detents and a residual, the divider done flag,
// the step/guard state and the load of the result register; the next item
// can be taken only once the result is loaded. A take, or a feed with zero
// difference or with detents disabled, skips the divider and goes straight
// to the result load. o_in_stall is high from a transfer until the result is
// loaded; the result register lets the next item in while the previous
// result waits.
// Configuration writes are always ready and are meant for an idle block.
module encoder_detent_quantizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic signed [15:0] i_count_diff,
    input  logic [31:0]        i_time_ms,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [7:0]  o_taken_delta,
    output logic signed [7:0]  o_pending_now,
    output logic signed [15:0] o_residual_now
);

    edq_pkg::t_state r_state;
    edq_pkg::t_state n_state;

    logic [14:0]        r_cpd;
    logic [31:0]        r_guard;
    logic signed [15:0] r_residual;
    logic signed [7:0]  r_pending;
    logic [31:0]        r_last_time;
    logic               r_stepped;
    logic               r_neg;
    logic [31:0]        r_time;
    logic [16:0]        r_nsteps;
    logic signed [7:0]  r_taken;
    logic               r_out_valid;
    logic signed [7:0]  r_out_taken;
    logic signed [7:0]  r_out_pending;
    logic signed [15:0] r_out_residual;

    logic               w_in_xfer;
    logic               w_is_take;
    logic               w_feed_active;
    logic               w_load_out;
    logic signed [17:0] w_sum;
    logic [16:0]        w_mag;
    logic [31:0]        w_elapsed;
    logic               w_blocked;
    logic [7:0]         w_accepted;
    logic signed [9:0]  w_pend_ext;
    logic signed [9:0]  w_acc_ext;
    logic signed [9:0]  w_moved;
    logic signed [7:0]  w_pend_sat;
    logic signed [15:0] w_res_new;

    edq_pkg::t_div_req  w_div_req;
    edq_pkg::t_div_rsp  w_div_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != edq_pkg::S_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_is_take   = (i_cmd == edq_pkg::CMD_TAKE);
    assign w_feed_active = !w_is_take && (r_cpd != '0) && (i_count_diff != '0);
    assign w_load_out  = (r_state == edq_pkg::S_OUT) && (!r_out_valid || !i_out_stall);

    // summed count and its magnitude for the divider
    always_comb begin
        w_sum = 18'(r_residual) + 18'(i_count_diff);
        w_mag = w_sum[17] ? 17'(-w_sum) : w_sum[16:0];
    end

    assign w_div_req.start    = w_in_xfer && w_feed_active;
    assign w_div_req.dividend = w_mag;
    assign w_div_req.divisor  = r_cpd;

    edq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // residual takes the sign of the sum
    assign w_res_new = r_neg ? -$signed({1'b0, w_div_rsp.remainder})
                             :  $signed({1'b0, w_div_rsp.remainder});

    // guard window, modulo 2^32
    always_comb begin
        w_elapsed = r_time - r_last_time;
        w_blocked = r_stepped && (w_elapsed < r_guard);
    end

    // steps applied to the pending delta, saturating
    always_comb begin
        if (r_guard != '0) begin
            w_accepted = 8'd1;
        end else if (r_nsteps[16:8] != '0) begin
            w_accepted = edq_pkg::STEP_CLAMP;
        end else begin
            w_accepted = r_nsteps[7:0];
        end
        w_pend_ext = 10'(r_pending);
        w_acc_ext  = $signed({2'b00, w_accepted});
        w_moved    = r_neg ? (w_pend_ext - w_acc_ext) : (w_pend_ext + w_acc_ext);
        if (w_moved > 10'(edq_pkg::PEND_MAX)) begin
            w_pend_sat = edq_pkg::PEND_MAX;
        end else if (w_moved < 10'(edq_pkg::PEND_MIN)) begin
            w_pend_sat = edq_pkg::PEND_MIN;
        end else begin
            w_pend_sat = w_moved[7:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            edq_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_div_req.start ? edq_pkg::S_DIV : edq_pkg::S_OUT;
                end
            end
            edq_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = edq_pkg::S_STEP;
                end
            end
            edq_pkg::S_STEP: begin
                n_state = edq_pkg::S_OUT;
            end
            edq_pkg::S_OUT: begin
                if (w_load_out) begin
                    n_state = edq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = edq_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= edq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpd   <= edq_pkg::CPD_RESET;
            r_guard <= edq_pkg::GUARD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                edq_pkg::CFG_CPD:   r_cpd   <= i_cfg_data[14:0];
                edq_pkg::CFG_GUARD: r_guard <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // block state: residual, pending delta, step history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_residual  <= '0;
            r_pending   <= '0;
            r_last_time <= '0;
            r_stepped   <= 1'b0;
        end else begin
            if (w_in_xfer && w_is_take) begin
                r_pending <= '0;
            end
            if ((r_state == edq_pkg::S_DIV) && w_div_rsp.done) begin
                r_residual <= w_res_new;
            end
            if ((r_state == edq_pkg::S_STEP) && (r_nsteps != '0) && !w_blocked) begin
                r_pending   <= w_pend_sat;
                r_last_time <= r_time;
                r_stepped   <= 1'b1;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_taken <= w_is_take ? r_pending : '0;
            r_neg   <= w_sum[17];
            r_time  <= i_time_ms;
        end
        if ((r_state == edq_pkg::S_DIV) && w_div_rsp.done) begin
            r_nsteps <= w_div_rsp.quotient;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_taken    <= r_taken;
            r_out_pending  <= r_pending;
            r_out_residual <= r_residual;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_taken_delta  = r_out_taken;
    assign o_pending_now  = r_out_pending;
    assign o_residual_now = r_out_residual;

    // checks
    `include "encoder_detent_quantizer_assert.svh"

    `EDQ_ASSERT_NEXT(a_busy_after_xfer, w_in_xfer, o_in_stall, "block not busy after input transfer")
    `EDQ_ASSERT_NEXT(a_take_clears, w_in_xfer && w_is_take, r_pending == '0, "take did not clear pending delta")
    `EDQ_ASSERT_NOW(a_div_done_in_div, w_div_rsp.done, r_state == edq_pkg::S_DIV, "divider finished outside division")

endmodule
